// ----- sv/mks_pkg.sv -----
// Shared types and constants for the matrix keypad scanner.
// No dependencies; every other file refers to this package by scoped names.
package mks_pkg;

    localparam int ROW_COUNT  = 3;
    localparam int COL_COUNT  = 3;
    localparam int KEY_W      = ROW_COUNT * COL_COUNT;
    localparam int CODE_W     = (KEY_W > 1) ? $clog2(KEY_W) : 1;
    localparam int ROW_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int FIFO_DEPTH = 16;

    localparam int GAP_W    = 16;
    localparam int SETTLE_W = 8;
    localparam int TICK_W   = 32;

    localparam logic [GAP_W-1:0]    GAP_RESET    = 16'd100;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd9;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_REPEAT_GAP = 1'b0;
    localparam logic REG_SETTLE     = 1'b1;

    // command word function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // entries in the result queue ahead of the output port
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 2;

    typedef struct packed {
        logic              push;
        logic [CODE_W-1:0] code;
    } push_req_t;

    typedef struct packed {
        logic push_ok;
        logic pop_ok;
        logic overflow;
    } fifo_stat_t;

endpackage

// ----- sv/mks_if.sv -----
// Valid/ready channel interfaces for the keypad scanner command and response words.
// Depends on mks_pkg for field widths.
interface mks_cmd_if;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [mks_pkg::KEY_W-1:0] key_matrix;

    modport source (output valid, output func, output key_matrix, input ready);
    modport sink   (input valid, input func, input key_matrix, output ready);
endinterface

interface mks_rsp_if #(parameter int CountW = 5);
    logic                      valid;
    logic                      ready;
    logic                      key_valid;
    logic [mks_pkg::CODE_W-1:0] key_code;
    logic                      key_accepted;
    logic [CountW-1:0]         fifo_count;
    logic                      overflow;
    logic                      scan_pending;

    modport source (output valid, output key_valid, output key_code, output key_accepted,
                    output fifo_count, output overflow, output scan_pending, input ready);
    modport sink   (input valid, input key_valid, input key_code, input key_accepted,
                    input fifo_count, input overflow, input scan_pending, output ready);
endinterface

// ----- sv/mks_scan_engine.sv -----
// Tick counter, row detect, settle wait and column scan with repeat suppression.
// Depends on mks_pkg.
module mks_scan_engine
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick,
    input  logic [mks_pkg::KEY_W-1:0]      key_matrix,
    input  logic [mks_pkg::GAP_W-1:0]      repeat_gap,
    input  logic [mks_pkg::SETTLE_W-1:0]   settle_ticks,
    output mks_pkg::push_req_t             push_req,
    output logic                           pending_next
);

    logic [mks_pkg::TICK_W-1:0]   tick_reg, tick_next, tick_inc, age;
    logic                         pending_reg;
    logic [mks_pkg::SETTLE_W-1:0] settle_reg, settle_next, settle_dec;
    logic [mks_pkg::ROW_W-1:0]    row_reg, row_next, row_sel;
    logic [mks_pkg::CODE_W-1:0]   last_code_reg, last_code_next;
    logic [mks_pkg::TICK_W-1:0]   last_time_reg, last_time_next;

    logic                          row_found;
    logic [mks_pkg::COL_COUNT-1:0] row_bits;
    logic [mks_pkg::CODE_W-1:0]    base, cand, hit_code;
    logic                          hit, age_big;

    always_comb
    begin
        row_found = 1'b0;
        row_sel   = '0;
        // walk down so the lowest active row wins
        for (int r = mks_pkg::ROW_COUNT - 1; r >= 0; r--)
        begin
            if (|key_matrix[r*mks_pkg::COL_COUNT +: mks_pkg::COL_COUNT])
            begin
                row_found = 1'b1;
                row_sel   = mks_pkg::ROW_W'(r);
            end
        end

        row_bits = '0;
        base     = '0;
        for (int r = 0; r < mks_pkg::ROW_COUNT; r++)
        begin
            if (row_reg == mks_pkg::ROW_W'(r))
            begin
                row_bits = key_matrix[r*mks_pkg::COL_COUNT +: mks_pkg::COL_COUNT];
                base     = mks_pkg::CODE_W'(r * mks_pkg::COL_COUNT);
            end
        end

        tick_inc = tick_reg + 1'b1;
        age      = tick_inc - last_time_reg;
        age_big  = age > mks_pkg::TICK_W'(repeat_gap);

        hit      = 1'b0;
        hit_code = '0;
        cand     = '0;
        for (int c = mks_pkg::COL_COUNT - 1; c >= 0; c--)
        begin
            cand = base + mks_pkg::CODE_W'(c);
            if (row_bits[c] && ((cand != last_code_reg) || age_big))
            begin
                hit      = 1'b1;
                hit_code = cand;
            end
        end

        settle_dec = (settle_reg != '0) ? settle_reg - 1'b1 : '0;

        tick_next      = tick_reg;
        pending_next   = pending_reg;
        settle_next    = settle_reg;
        row_next       = row_reg;
        last_code_next = last_code_reg;
        last_time_next = last_time_reg;
        push_req.push  = 1'b0;
        push_req.code  = hit_code;

        if (tick)
        begin
            tick_next = tick_inc;
            if (pending_reg)
            begin
                settle_next = settle_dec;
                if (settle_dec == '0)
                begin
                    pending_next = 1'b0;
                    if (hit)
                    begin
                        push_req.push  = 1'b1;
                        last_code_next = hit_code;
                        last_time_next = tick_inc;
                    end
                end
            end
            else if (row_found)
            begin
                pending_next = 1'b1;
                row_next     = row_sel;
                settle_next  = (settle_ticks != '0) ? settle_ticks
                                                    : mks_pkg::SETTLE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            pending_reg   <= 1'b0;
            settle_reg    <= '0;
            row_reg       <= '0;
            last_code_reg <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            tick_reg      <= tick_next;
            pending_reg   <= pending_next;
            settle_reg    <= settle_next;
            row_reg       <= row_next;
            last_code_reg <= last_code_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

// ----- sv/mks_key_fifo.sv -----
// Key code FIFO: storage array, pointers, fill count, sticky overflow, registered read.
// Depends on mks_pkg.
module mks_key_fifo
#(
    parameter int FIFO_DEPTH = mks_pkg::FIFO_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mks_pkg::push_req_t          push_req,
    input  logic                        pop,
    output mks_pkg::fifo_stat_t         stat,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] count_next,
    output logic [mks_pkg::CODE_W-1:0]  rdata
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [mks_pkg::CODE_W-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       overflow_reg;
    logic [mks_pkg::CODE_W-1:0] rdata_reg;
    logic                       full, push_ok, pop_ok;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign push_ok = push_req.push && !full;
    assign pop_ok  = pop && (count_reg != '0);

    assign stat.push_ok  = push_ok;
    assign stat.pop_ok   = pop_ok;
    assign stat.overflow = overflow_reg || (push_req.push && full);

    // push and pop never come from the same word
    always_comb
    begin
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= stat.overflow;
            if (push_ok)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= push_req.code;
        end
        if (pop_ok)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/mks_out_queue.sv -----
// Small response queue between the result register and the output channel.
// Depends on mks_pkg for its depth.
module mks_out_queue
#(
    parameter int DATA_W = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [DATA_W-1:0]             push_data,
    input  logic                          pop_ready,
    output logic                          valid,
    output logic [DATA_W-1:0]             data,
    output logic [mks_pkg::OUTQ_CNT_W-1:0] count
);

    logic [DATA_W-1:0]              entry_reg [mks_pkg::OUTQ_DEPTH];
    logic [mks_pkg::OUTQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mks_pkg::OUTQ_CNT_W-1:0] count_reg;
    logic                           pop;

    assign valid = (count_reg != '0);
    assign pop   = valid && pop_ready;
    assign data  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mks_pkg::OUTQ_PTR_W'(mks_pkg::OUTQ_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mks_pkg::OUTQ_PTR_W'(mks_pkg::OUTQ_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/matrix_keypad_scanner.sv -----
// Matrix keypad scanner: one command word per cycle while cmd.ready is high; each response
// goes through the result register and then the response queue before it shows on rsp.
// Throughput: one word per cycle; a three-entry response queue lets words keep coming
// until three responses wait in the queue and result register on a stalled rsp channel.
// Reset (rst_n, async, low): pointers, counts, flags and tick counter clear;
// repeat_gap = 100, settle_ticks = 9. FIFO contents are not cleared.
module matrix_keypad_scanner
#(
    parameter int FIFO_DEPTH = mks_pkg::FIFO_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    mks_cmd_if.sink                         cmd,
    mks_rsp_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mks_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mks_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mks_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int RSP_W = 1 + mks_pkg::CODE_W + 1 + CNT_W + 1 + 1;

    // configuration registers
    logic [mks_pkg::GAP_W-1:0]    gap_reg;
    logic [mks_pkg::SETTLE_W-1:0] settle_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= mks_pkg::GAP_RESET;
            settle_reg <= mks_pkg::SETTLE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                mks_pkg::REG_REPEAT_GAP: gap_reg    <= pwdata[mks_pkg::GAP_W-1:0];
                mks_pkg::REG_SETTLE:     settle_reg <= pwdata[mks_pkg::SETTLE_W-1:0];
                default:                 gap_reg    <= gap_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mks_pkg::REG_REPEAT_GAP: prdata = mks_pkg::APB_DATA_W'(gap_reg);
            mks_pkg::REG_SETTLE:     prdata = mks_pkg::APB_DATA_W'(settle_reg);
            default:                 prdata = '0;
        endcase
    end

    // command acceptance
    logic                            accept, tick, pop;
    logic [mks_pkg::OUTQ_CNT_W-1:0]  q_count;
    logic                            a_valid_reg;

    assign cmd.ready = ({1'b0, q_count} + {{mks_pkg::OUTQ_CNT_W{1'b0}}, a_valid_reg})
                       < (mks_pkg::OUTQ_CNT_W+1)'(mks_pkg::OUTQ_DEPTH);
    assign accept    = cmd.valid && cmd.ready;
    assign tick      = accept && (cmd.func == mks_pkg::FUNC_TICK);
    assign pop       = accept && (cmd.func == mks_pkg::FUNC_READ);

    mks_pkg::push_req_t         push_req;
    logic                       pending_next;
    mks_pkg::fifo_stat_t        fstat;
    logic [CNT_W-1:0]           count_next;
    logic [mks_pkg::CODE_W-1:0] rdata;

    mks_scan_engine u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .key_matrix   (cmd.key_matrix),
        .repeat_gap   (gap_reg),
        .settle_ticks (settle_reg),
        .push_req     (push_req),
        .pending_next (pending_next)
    );

    mks_key_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_req   (push_req),
        .pop        (pop),
        .stat       (fstat),
        .count_next (count_next),
        .rdata      (rdata)
    );

    // result register; the popped code arrives from the FIFO read register
    logic             a_key_valid_reg, a_accepted_reg, a_overflow_reg, a_pending_reg;
    logic [CNT_W-1:0] a_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_key_valid_reg <= fstat.pop_ok;
            a_accepted_reg  <= fstat.push_ok;
            a_count_reg     <= count_next;
            a_overflow_reg  <= fstat.overflow;
            a_pending_reg   <= pending_next;
        end
    end

    logic [mks_pkg::CODE_W-1:0] a_code;
    logic [RSP_W-1:0]           a_word, q_word;

    assign a_code = a_key_valid_reg ? rdata : '0;
    assign a_word = {a_key_valid_reg, a_code, a_accepted_reg, a_count_reg,
                     a_overflow_reg, a_pending_reg};

    mks_out_queue #(.DATA_W(RSP_W)) u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (a_valid_reg),
        .push_data (a_word),
        .pop_ready (rsp.ready),
        .valid     (rsp.valid),
        .data      (q_word),
        .count     (q_count)
    );

    assign {rsp.key_valid, rsp.key_code, rsp.key_accepted, rsp.fifo_count,
            rsp.overflow, rsp.scan_pending} = q_word;

endmodule

// ----- sv/mks_checker.sv -----
// Port-level checks for the keypad scanner response channel, bound to the top level.
// Depends on mks_pkg and matrix_keypad_scanner.
module mks_checker
#(
    parameter int FIFO_DEPTH = mks_pkg::FIFO_DEPTH
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic                              key_valid,
    input logic [mks_pkg::CODE_W-1:0]        key_code,
    input logic                              key_accepted,
    input logic [$clog2(FIFO_DEPTH+1)-1:0]   fifo_count,
    input logic                              overflow,
    input logic                              scan_pending
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [mks_pkg::CODE_W+CNT_W+3:0] rsp_word;

    assign rsp_word = {key_valid, key_code, key_accepted, fifo_count, overflow, scan_pending};

    // stalled word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("rsp word changed while stalled");

    // a word is either a read or a tick, never both outcomes
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(key_valid && key_accepted))
        else $error("read and accept flagged in one word");

    a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !key_valid |-> key_code == '0)
        else $error("code nonzero without a popped key");

    // a key is queued only on the tick that ends the settle wait
    a_accept_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && key_accepted |-> !scan_pending && (fifo_count != '0))
        else $error("accepted key with wait still running or empty fifo");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> fifo_count <= CNT_W'(FIFO_DEPTH))
        else $error("fifo count above depth");

endmodule

bind matrix_keypad_scanner mks_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_mks_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .key_valid    (rsp.key_valid),
    .key_code     (rsp.key_code),
    .key_accepted (rsp.key_accepted),
    .fifo_count   (rsp.fifo_count),
    .overflow     (rsp.overflow),
    .scan_pending (rsp.scan_pending)
);

// ----- test/tb.sv -----
// Self-checking testbench for matrix_keypad_scanner: tick and read words go in,
// response words are checked field by field against an in-bench keypad predictor.
// Depends on mks_pkg, the mks_cmd_if/mks_rsp_if interfaces and the scanner RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_W = $clog2(mks_pkg::FIFO_DEPTH);

    typedef struct packed {
        logic                       key_valid;
        logic [mks_pkg::CODE_W-1:0] key_code;
        logic                       key_accepted;
        logic [4:0]                 fifo_count;
        logic                       overflow;
        logic                       scan_pending;
    } keypad_report_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mks_pkg::APB_ADDR_W-1:0] paddr;
    logic [mks_pkg::APB_DATA_W-1:0] pwdata;
    logic [mks_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    mks_cmd_if                 cmd_ch();
    mks_rsp_if #(.CountW(5))   rsp_ch();

    matrix_keypad_scanner u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [mks_pkg::CODE_W-1:0]   key_fifo [mks_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]             wr_ptr;
    logic [PTR_W-1:0]             rd_ptr;
    logic [4:0]                   queued;
    logic [mks_pkg::SETTLE_W-1:0] settle_left;
    logic                         settle_busy;
    logic [mks_pkg::ROW_W-1:0]    latched_row;
    logic [mks_pkg::CODE_W-1:0]   prev_code;
    logic [mks_pkg::TICK_W-1:0]   prev_tick;
    logic [mks_pkg::TICK_W-1:0]   tick_ctr;
    logic                         key_dropped;
    logic [mks_pkg::GAP_W-1:0]    gap_cfg;
    logic [mks_pkg::SETTLE_W-1:0] settle_cfg;

    keypad_report_t awaited_reports[$];

    int mismatch_count = 0;
    int words_sent     = 0;
    int reads_sent     = 0;
    int keys_queued    = 0;
    int keys_dropped   = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int settle_span();
        return (settle_cfg == 0) ? 1 : int'(settle_cfg);
    endfunction

    function automatic keypad_report_t advance_keypad(
        input logic                      func,
        input logic [mks_pkg::KEY_W-1:0] keys);
        keypad_report_t             r;
        int                         row;
        int                         col;
        logic [mks_pkg::CODE_W-1:0] code;
        logic [mks_pkg::TICK_W-1:0] age;
        bit                         found;
        r = '0;
        found = 1'b0;
        if (func == mks_pkg::FUNC_TICK)
        begin
            tick_ctr = tick_ctr + 1;
            if (settle_busy)
            begin
                if (settle_left != 0)
                    settle_left = settle_left - 1;
                if (settle_left == 0)
                begin
                    settle_busy = 1'b0;
                    // a repeated code within the gap lets the scan move on to the next column
                    for (col = 0; col < mks_pkg::COL_COUNT && !found; col++)
                    begin
                        if (keys[latched_row * mks_pkg::COL_COUNT + col])
                        begin
                            code = mks_pkg::CODE_W'(latched_row * mks_pkg::COL_COUNT + col);
                            age = tick_ctr - prev_tick;
                            if (code != prev_code || age > mks_pkg::TICK_W'(gap_cfg))
                            begin
                                found = 1'b1;
                                prev_tick = tick_ctr;
                                prev_code = code;
                                if (queued >= mks_pkg::FIFO_DEPTH)
                                begin
                                    key_dropped = 1'b1;
                                    keys_dropped++;
                                end
                                else
                                begin
                                    key_fifo[wr_ptr] = code;
                                    wr_ptr = wr_ptr + 1;
                                    queued = queued + 1;
                                    r.key_accepted = 1'b1;
                                    keys_queued++;
                                end
                            end
                        end
                    end
                end
            end
            else
            begin
                for (row = 0; row < mks_pkg::ROW_COUNT && !found; row++)
                begin
                    if (keys[row * mks_pkg::COL_COUNT +: mks_pkg::COL_COUNT] != 0)
                    begin
                        found = 1'b1;
                        latched_row = mks_pkg::ROW_W'(row);
                    end
                end
                if (found)
                begin
                    settle_busy = 1'b1;
                    settle_left = mks_pkg::SETTLE_W'(settle_span());
                end
            end
        end
        else if (queued != 0)
        begin
            r.key_valid = 1'b1;
            r.key_code = key_fifo[rd_ptr];
            rd_ptr = rd_ptr + 1;
            queued = queued - 1;
        end
        r.fifo_count = queued;
        r.overflow = key_dropped;
        r.scan_pending = settle_busy;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // response side: random stall, compare each accepted word with the oldest prediction
    always @(posedge clk)
    begin
        keypad_report_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("response word arrived with no prediction waiting");
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("key_valid", want.key_valid, rsp_ch.key_valid);
                    check_field("key_code", want.key_code, rsp_ch.key_code);
                    check_field("key_accepted", want.key_accepted, rsp_ch.key_accepted);
                    check_field("fifo_count", want.fifo_count, rsp_ch.fifo_count);
                    check_field("overflow", want.overflow, rsp_ch.overflow);
                    check_field("scan_pending", want.scan_pending, rsp_ch.scan_pending);
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
        else
        begin
            rsp_ch.ready <= 1'b0;
        end
    end

    task automatic send_word(input logic func, input logic [mks_pkg::KEY_W-1:0] keys);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= func;
        cmd_ch.key_matrix <= keys;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        awaited_reports.push_back(advance_keypad(func, keys));
        words_sent++;
        if (func == mks_pkg::FUNC_READ)
            reads_sent++;
    endtask

    task automatic tick(input logic [mks_pkg::KEY_W-1:0] keys);
        send_word(mks_pkg::FUNC_TICK, keys);
    endtask

    // the matrix is ignored on reads, so it carries random bits
    task automatic read_key();
        send_word(mks_pkg::FUNC_READ, mks_pkg::KEY_W'($urandom_range(511)));
    endtask

    task automatic press(input logic [mks_pkg::KEY_W-1:0] keys);
        repeat (settle_span() + 1)
            tick(keys);
    endtask

    task automatic idle_bus();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        idle_bus();
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [mks_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == mks_pkg::REG_REPEAT_GAP)
            gap_cfg = value[mks_pkg::GAP_W-1:0];
        else
            settle_cfg = value[mks_pkg::SETTLE_W-1:0];
    endtask

    task automatic set_timing(input logic [mks_pkg::APB_DATA_W-1:0] gap,
                              input logic [mks_pkg::APB_DATA_W-1:0] settle);
        drain();
        write_reg(mks_pkg::REG_REPEAT_GAP, gap);
        write_reg(mks_pkg::REG_SETTLE, settle);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        // reset timing: settle 9, gap 100
        read_key();
        press(9'h010);
        read_key();
        // settle of zero behaves as one
        set_timing(0, 0);
        tick(9'h000);
        press(9'h1FF);
        tick(9'h100);
        tick(9'h000);           // released during the wait
        press(9'h100);
        press(9'h0C0);
        press(9'h038);
        repeat (5)
            read_key();
        // upper register bits are ignored
        set_timing(32'hFFFF_FFFF, 32'h5A5A_0001);
        press(9'h004);
        press(9'h004);          // same code inside the gap: suppressed
        press(9'h003);
        press(9'h003);          // first column repeats, second column taken
        repeat (3)
            read_key();
    endtask

    task automatic test_overflow();
        set_timing(0, 1);
        repeat (mks_pkg::FIFO_DEPTH + 2)
            press(mks_pkg::KEY_W'(1) << $urandom_range(mks_pkg::KEY_W - 1));
        repeat (mks_pkg::FIFO_DEPTH + 1)
            read_key();
    endtask

    task automatic test_long_settle();
        set_timing($urandom_range(65535), 255);
        tick(9'h020);
        repeat (3)
            read_key();
        repeat (255)
            tick(9'h020);
        read_key();
    endtask

    task automatic run_traffic(input int words, input int idle, input int stall,
                               input bit pause_midway);
        int                        stop_at;
        int                        pick;
        int                        i;
        int                        span;
        bit                        broken;
        logic [mks_pkg::KEY_W-1:0] keys;
        idle_pct = idle;
        stall_pct = stall;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            if (pause_midway && words_sent >= stop_at - words / 2)
            begin
                drain();
                pause_midway = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                if ($urandom_range(1))
                    keys = mks_pkg::KEY_W'(1) << $urandom_range(mks_pkg::KEY_W - 1);
                else
                    keys = mks_pkg::KEY_W'($urandom_range(1, 511));
                broken = ($urandom_range(9) == 0);
                span = settle_span() + 1;
                for (i = 0; i < span; i++)
                begin
                    if ($urandom_range(9) == 0)
                        read_key();
                    if (broken && i == span - 1)
                        tick(mks_pkg::KEY_W'($urandom_range(511)));
                    else
                        tick(keys);
                end
            end
            else if (pick < 82)
            begin
                repeat ($urandom_range(1, 4))
                    read_key();
            end
            else if (pick < 92)
                tick(mks_pkg::KEY_W'($urandom_range(511)));
            else
                tick('0);
        end
    endtask

    initial
    begin
        int waited;
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.func       <= mks_pkg::FUNC_TICK;
        cmd_ch.key_matrix <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;

        wr_ptr      = '0;
        rd_ptr      = '0;
        queued      = '0;
        settle_left = '0;
        settle_busy = 1'b0;
        latched_row = '0;
        prev_code   = '0;
        prev_tick   = '0;
        tick_ctr    = '0;
        key_dropped = 1'b0;
        gap_cfg     = mks_pkg::GAP_RESET;
        settle_cfg  = mks_pkg::SETTLE_RESET;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow();
        set_timing(3, 2);
        run_traffic(350, 0, 0, 1'b0);
        set_timing($urandom_range(1, 40), 1);
        run_traffic(350, 78, 0, 1'b1);
        set_timing(0, 3);
        run_traffic(350, 0, 78, 1'b0);
        set_timing(65535, $urandom_range(1, 5));
        run_traffic(350, 26, 26, 1'b0);
        test_long_settle();

        idle_bus();
        waited = 0;
        while (awaited_reports.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10)
            @(posedge clk);
        if (awaited_reports.size() != 0)
        begin
            $error("%0d predicted response words never arrived", awaited_reports.size());
            mismatch_count++;
        end

        $display("Run covered %0d words (%0d reads), %0d keys queued, %0d dropped when full,",
                 words_sent, reads_sent, keys_queued, keys_dropped);
        $display("under settle times 0 to 255, repeat gaps 0 to 65535 and four stall patterns.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/mks_pkg.sv
sv/mks_if.sv
sv/mks_scan_engine.sv
sv/mks_key_fifo.sv
sv/mks_out_queue.sv
sv/matrix_keypad_scanner.sv
sv/mks_checker.sv
test/tb.sv
